@@ hdl/sclt_pkg.sv @@
`timescale 1ns / 1ps
// Package for the slot table with lifetime aging.
// Holds table size, field widths, action codes and the slot entry type.
// No dependencies.
package sclt_pkg;

  // Table geometry
  localparam int ENTRIES = 512;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int CNT_W   = ADDR_W + 1;

  // Field widths
  localparam int ACTION_W = 3;
  localparam int SLOT_W   = 9;
  localparam int LIFE_W   = 8;

  // Lifetime reload value after reset
  localparam logic [LIFE_W-1:0] LIFE_RESET = 8'h3C;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TOUCH   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FLUSH   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd5;

  // One slot as stored in the table memory
  typedef struct packed {
    logic              alive;
    logic              present;
    logic [LIFE_W-1:0] life;
  } entry_t;

endpackage

@@ hdl/sclt_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the slot table: valid/ready with action and slot index.
// Depends on sclt_pkg.
interface sclt_req_if;
  logic                              valid;
  logic                              ready;
  logic [sclt_pkg::ACTION_W-1:0]     action;
  logic [sclt_pkg::SLOT_W-1:0]       slot_index;

  modport source (output valid, output action, output slot_index, input ready);
  modport sink   (input valid, input action, input slot_index, output ready);
endinterface

@@ hdl/sclt_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel of the slot table: valid/ready with slot and status flags.
// Depends on sclt_pkg.
interface sclt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sclt_pkg::SLOT_W-1:0] slot_out;
  logic                        created;
  logic                        in_use;
  logic                        table_full;

  modport source (output valid, output slot_out, output created, output in_use,
                  output table_full, input ready);
  modport sink   (input valid, input slot_out, input created, input in_use,
                  input table_full, output ready);
endinterface

@@ hdl/slot_cache_with_lifetime_core.sv @@
`timescale 1ns / 1ps
// Slot table with lifetime aging: allocate, release, touch, tick, flush, query.
// Depends on sclt_pkg, sclt_req_if and sclt_rsp_if.
//
//  channel   direction  handshake        payload
//  req       in         valid / ready    action, slot_index
//  rsp       out        valid / ready    slot_out, created, in_use, table_full
//  cfg       in         cfg_wr_en        cfg_wr_data (life reload)
//
// A clearing pass after reset comes before the first request.
// Release, touch and query work on their one entry; unused actions go straight to
// the result. Allocate, tick and flush sweep the table memory one entry per cycle,
// allocate stopping at the first free entry.
// One request is in work at a time. A new request is taken while a result waits in
// the output register, then stalls in its last cycle until that result is taken.
module slot_cache_with_lifetime_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [sclt_pkg::LIFE_W-1:0] cfg_wr_data,
  sclt_req_if.sink                    req,
  sclt_rsp_if.source                  rsp
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_EX    = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [sclt_pkg::CNT_W-1:0]  CNT_END  = sclt_pkg::CNT_W'(sclt_pkg::ENTRIES);
  localparam logic [sclt_pkg::ADDR_W-1:0] ADDR_END = sclt_pkg::ADDR_W'(sclt_pkg::ENTRIES - 1);

  // Table memory
  sclt_pkg::entry_t mem [sclt_pkg::ENTRIES];
  sclt_pkg::entry_t rd_data;
  logic [sclt_pkg::ADDR_W-1:0] rd_addr;
  logic                        mem_we;
  logic [sclt_pkg::ADDR_W-1:0] mem_wa;
  sclt_pkg::entry_t            mem_wd;

  // Control registers
  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [sclt_pkg::ADDR_W-1:0]   clr_cnt;
  logic [sclt_pkg::CNT_W-1:0]    issue_cnt;
  logic                          rd_pend;
  logic [sclt_pkg::LIFE_W-1:0]   life_reload;
  logic                          out_valid;

  // Request registers
  logic [sclt_pkg::ACTION_W-1:0] act_q;
  logic [sclt_pkg::ADDR_W-1:0]   addr_q;
  logic                          idx_ok;
  logic [sclt_pkg::ADDR_W-1:0]   pend_addr;

  // Result registers
  logic [sclt_pkg::SLOT_W-1:0]   res_slot;
  logic                          res_created;
  logic                          res_in_use;
  logic                          res_full;
  logic [sclt_pkg::SLOT_W-1:0]   out_slot;
  logic                          out_created;
  logic                          out_in_use;
  logic                          out_full;

  // Combinational helpers
  logic                        issue_ok;
  logic                        alloc_hit;
  logic                        alloc_full;
  logic                        advance;
  logic [sclt_pkg::LIFE_W-1:0] life_dec;
  logic                        req_alloc;
  logic                        req_sweep;
  logic                        req_single;

  assign req.ready   = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.slot_out   = out_slot;
  assign rsp.created    = out_created;
  assign rsp.in_use     = out_in_use;
  assign rsp.table_full = out_full;

  // Decode of the incoming action
  assign req_alloc  = (req.action == sclt_pkg::ACT_ALLOC);
  assign req_sweep  = req_alloc || (req.action == sclt_pkg::ACT_TICK) ||
                      (req.action == sclt_pkg::ACT_FLUSH);
  assign req_single = (req.action == sclt_pkg::ACT_RELEASE) ||
                      (req.action == sclt_pkg::ACT_TOUCH) ||
                      (req.action == sclt_pkg::ACT_QUERY);

  assign issue_ok = (state == ST_SCAN) && (issue_cnt < CNT_END);
  assign life_dec = (rd_data.life != '0) ? rd_data.life - 1'b1 : '0;
  assign advance  = !out_valid || rsp.ready;
  assign alloc_hit  = (state == ST_SCAN) && rd_pend && (act_q == sclt_pkg::ACT_ALLOC) &&
                      !rd_data.alive;
  assign alloc_full = (state == ST_SCAN) && !rd_pend && !issue_ok &&
                      (act_q == sclt_pkg::ACT_ALLOC);

  // Next state and memory port control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wa     = addr_q;
    mem_wd     = '0;
    rd_addr    = addr_q;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
        if (clr_cnt == ADDR_END) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) begin
          if (req_sweep) state_next = ST_SCAN;
          else if (req_single) state_next = ST_RD;
          else state_next = ST_DONE;
        end
      end
      ST_RD: begin
        state_next = ST_EX;
      end
      ST_EX: begin
        if (idx_ok && act_q == sclt_pkg::ACT_RELEASE) begin
          mem_we = 1'b1;
        end else if (idx_ok && act_q == sclt_pkg::ACT_TOUCH) begin
          mem_we         = 1'b1;
          mem_wd.alive   = rd_data.alive;
          mem_wd.present = 1'b1;
          mem_wd.life    = life_reload;
        end
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        rd_addr = issue_cnt[sclt_pkg::ADDR_W-1:0];
        mem_wa  = pend_addr;
        if (rd_pend) begin
          case (act_q)
            sclt_pkg::ACT_TICK: begin
              mem_we         = rd_data.alive && rd_data.present;
              mem_wd.alive   = 1'b1;
              mem_wd.present = (life_dec != '0);
              mem_wd.life    = life_dec;
            end
            sclt_pkg::ACT_FLUSH: begin
              mem_we       = rd_data.alive;
              mem_wd.alive = 1'b1;
            end
            default: begin
              if (alloc_hit) begin
                mem_we       = 1'b1;
                mem_wd.alive = 1'b1;
                state_next   = ST_DONE;
              end
            end
          endcase
        end else if (!issue_ok) begin
          // Sweep finished; a full table falls back to slot 0
          if (alloc_full) begin
            mem_we       = 1'b1;
            mem_wa       = '0;
            mem_wd.alive = 1'b1;
          end
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (advance) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Table memory, one read and one write port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      issue_cnt   <= '0;
      rd_pend     <= 1'b0;
      life_reload <= sclt_pkg::LIFE_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) life_reload <= cfg_wr_data;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_IDLE && req.valid) begin
        issue_cnt <= req_alloc ? sclt_pkg::CNT_W'(1) : '0;
        rd_pend   <= 1'b0;
      end else if (state == ST_SCAN) begin
        rd_pend <= issue_ok;
        if (issue_ok) issue_cnt <= issue_cnt + 1'b1;
      end
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      if (state == ST_DONE && advance) out_valid <= 1'b1;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      act_q       <= req.action;
      addr_q      <= sclt_pkg::ADDR_W'(req.slot_index);
      idx_ok      <= (int'(req.slot_index) < sclt_pkg::ENTRIES);
      res_slot    <= req.slot_index;
      res_created <= 1'b0;
      res_in_use  <= 1'b0;
      res_full    <= 1'b0;
    end
    if (state == ST_SCAN) pend_addr <= issue_cnt[sclt_pkg::ADDR_W-1:0];
    if (state == ST_EX) begin
      if (act_q == sclt_pkg::ACT_TOUCH) res_created <= idx_ok && !rd_data.present;
      if (act_q == sclt_pkg::ACT_QUERY) res_in_use  <= idx_ok && rd_data.present;
    end
    if (alloc_hit) res_slot <= sclt_pkg::SLOT_W'(pend_addr);
    if (alloc_full) begin
      res_slot <= '0;
      res_full <= 1'b1;
    end
    if (state == ST_DONE && advance) begin
      out_slot    <= res_slot;
      out_created <= res_created;
      out_in_use  <= res_in_use;
      out_full    <= res_full;
    end
  end

endmodule

@@ hdl/sclt_chk.sv @@
`timescale 1ns / 1ps
// Port checker for the slot table, bound to slot_cache_with_lifetime_core.
// Depends on sclt_pkg and the top level's ports.
module sclt_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [sclt_pkg::SLOT_W-1:0]   rsp_slot_out,
  input logic                          rsp_created,
  input logic                          rsp_in_use,
  input logic                          rsp_table_full
);

  // A stalled result stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_slot_out) && $stable(rsp_table_full))
    else $error("result payload changed while stalled");

  // Only one request is in work, so ready drops after each accepted request.
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in work");

  // A full table always falls back to slot 0.
  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_table_full |-> rsp_slot_out == '0)
    else $error("table full with nonzero slot");

  // Each action raises at most one status flag.
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot0({rsp_created, rsp_in_use, rsp_table_full}))
    else $error("more than one status flag set");

endmodule

bind slot_cache_with_lifetime_core sclt_chk u_sclt_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_slot_out   (rsp.slot_out),
  .rsp_created    (rsp.created),
  .rsp_in_use     (rsp.in_use),
  .rsp_table_full (rsp.table_full)
);
